@@ design/dwpid_pkg.sv @@
`default_nettype none

package dwpid_pkg;

    // drive accumulator limits
    localparam logic signed [15:0] DRIVE_MAX = 16'sd10000;
    localparam logic signed [15:0] DRIVE_MIN = -16'sd10000;

    // wheel target limits (20-bit signed range)
    localparam logic signed [19:0] TGT_MAX = 20'sd524287;
    localparam logic signed [19:0] TGT_MIN = -20'sd524288;

    // mix factor denominator
    localparam logic [13:0] DIV_BASE = 14'd10000;

    // floor(2^45 / 10000): quotient estimate is exact or one low below 2^33
    localparam logic [31:0] RECIP       = 32'd3518437208;
    localparam int          RECIP_SHIFT = 45;

    // |speed * scale| at or above 524288 * 10000 saturates the target
    localparam logic [45:0] SAT_LIMIT = 46'd5242880000;

    // rounding bias of the Q8.8 sum: +128, and +128+255 for truncation below zero
    localparam logic signed [41:0] ROUND_POS = 42'sd128;
    localparam logic signed [41:0] ROUND_NEG = 42'sd383;
    localparam logic signed [40:0] ROUND_EDGE = -41'sd128;

    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_RAMP_GAIN_P,
        REG_RAMP_GAIN_I,
        REG_STEER_MIX,
        REG_STOP_STEER_MIX,
        REG_STEER_CENTER
    } reg_idx_t;

endpackage

`default_nettype wire

@@ design/dual_wheel_incremental_pid_top.sv @@
// Dual-wheel incremental PID speed controller.
// Configuration goes through the APB-style port (gains, mix factors, steering
// center); write it only while no transfer is in flight.
// One input transfer per control tick on s_*: encoder counts, steering duty,
// base speed, and the mode flags in s_tuser. One result transfer on m_*
// carries both drives, the four PWM duties and the mean speed.
// A single 18x33 multiplier is stepped through all products by the sequencer,
// one product per cycle, so the item period is set by the multiply count:
//   targets recomputed (stop line seen or no protection): mix, targets, PID
//   targets held (protection active):                     PID products only
//   drive disabled (history cleared, zero duties):        no products
// s_tready is high only while the sequencer is idle; it does not wait for the
// previous result to be taken. If m_tready is held low the finished result
// waits in the output register and the next one stalls in its final step.
// Reset clears the state, configuration registers, targets, error history and accumulators.
`default_nettype none

module dual_wheel_incremental_pid_top
    import dwpid_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // right_count[15:0], left_raw_count[31:16], steer_duty[47:32],
    // target_speed[62:48], zero pad[63]
    input  wire logic [63:0]  s_tdata,
    // drive_enable[0], protect_active[1], stop_line_seen[2], ramp_active[3]
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // left_drive[15:0], right_drive[31:16], left_forward_duty[46:32],
    // left_reverse_duty[61:47], right_forward_duty[76:62],
    // right_reverse_duty[91:77], mean_speed[107:92], zero pad[111:108]
    output logic      [111:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_SCALE,
        ST_RECIP_HI,
        ST_RECIP_LO,
        ST_BACK,
        ST_FIX,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_ROUND,
        ST_ACCUM,
        ST_WRITE
    } state_t;

    function automatic logic [29:0] split_drive(input logic signed [15:0] drv);
        logic [16:0] mag;
        mag = 17'd0 - {drv[15], drv};
        if (!drv[15]) begin
            return {15'd0, drv[14:0]};
        end else if (mag[15]) begin
            return {15'h7fff, 15'd0};
        end else begin
            return {mag[14:0], 15'd0};
        end
    endfunction

    // control state
    state_t state_reg, state_next;
    logic   wheel_reg, wheel_next;
    logic   m_valid_reg, m_valid_next;

    // configuration
    logic [15:0] gain_p_reg, gain_p_next;
    logic [15:0] gain_i_reg, gain_i_next;
    logic [15:0] gain_d_reg, gain_d_next;
    logic [15:0] ramp_gain_p_reg, ramp_gain_p_next;
    logic [15:0] ramp_gain_i_reg, ramp_gain_i_next;
    logic [13:0] steer_mix_reg, steer_mix_next;
    logic [13:0] stop_steer_mix_reg, stop_steer_mix_next;
    logic [15:0] steer_center_reg, steer_center_next;

    // controller state
    logic signed [19:0] left_target_reg, left_target_next;
    logic signed [19:0] right_target_reg, right_target_next;
    logic signed [20:0] left_err_last_reg, left_err_last_next;
    logic signed [20:0] left_err_older_reg, left_err_older_next;
    logic signed [20:0] right_err_last_reg, right_err_last_next;
    logic signed [20:0] right_err_older_reg, right_err_older_next;
    logic signed [15:0] left_drive_acc_reg, left_drive_acc_next;
    logic signed [15:0] right_drive_acc_reg, right_drive_acc_next;

    // item payload and datapath
    logic signed [15:0] cur_r_reg, cur_r_next;
    logic signed [16:0] cur_l_reg, cur_l_next;
    logic [15:0]        steer_reg, steer_next;
    logic [14:0]        spd_reg, spd_next;
    logic               stop_reg, stop_next;
    logic               ramp_reg, ramp_next;
    logic signed [30:0] me_reg, me_next;
    logic signed [46:0] prod_reg, prod_next;
    logic [64:0]        macc_reg, macc_next;
    logic [33:0]        pq_reg, pq_next;
    logic signed [40:0] s_acc_reg, s_acc_next;
    logic signed [33:0] delta_reg, delta_next;
    logic [111:0]       m_data_reg, m_data_next;

    // shared multiplier
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_p;

    // target path
    logic signed [16:0] err_s;
    logic [13:0]        mix_sel;
    logic signed [31:0] scale;
    logic signed [46:0] prod_neg;
    logic [45:0]        prod_abs;
    logic               prod_sat;
    logic [32:0]        x33;
    logic [19:0]        q0;
    logic [33:0]        rem;
    logic [19:0]        q;
    logic [19:0]        q_neg;
    logic signed [19:0] tgt_new;

    // pid path
    logic signed [19:0] tgt_sel;
    logic signed [16:0] cur_sel;
    logic signed [20:0] last_sel;
    logic signed [20:0] older_sel;
    logic signed [15:0] acc_sel;
    logic signed [20:0] e1;
    logic signed [21:0] dp;
    logic signed [22:0] dd;
    logic [15:0]        gain_p_sel;
    logic [15:0]        gain_i_sel;
    logic signed [41:0] s_ext;
    logic signed [41:0] rnd;
    logic signed [34:0] acc_sum;
    logic signed [15:0] acc_new;

    logic [29:0]        left_split;
    logic [29:0]        right_split;
    logic signed [17:0] count_sum;
    logic               cfg_we;
    reg_idx_t           cfg_idx;
    logic               out_free;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign cfg_we   = psel & penable & pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[4:2]);
    assign out_free = !m_valid_reg || m_tready;

    // target: trunc(spd * (10000 -/+ mix * err) / 10000), saturated
    assign err_s    = $signed({1'b0, steer_reg}) - $signed({1'b0, steer_center_reg});
    assign mix_sel  = stop_reg ? stop_steer_mix_reg : steer_mix_reg;
    assign scale    = wheel_reg ? $signed({18'd0, DIV_BASE}) + $signed({me_reg[30], me_reg})
                                : $signed({18'd0, DIV_BASE}) - $signed({me_reg[30], me_reg});
    assign prod_neg = -prod_reg;
    assign prod_abs = prod_reg[46] ? prod_neg[45:0] : prod_reg[45:0];
    assign prod_sat = (prod_abs >= SAT_LIMIT);
    assign x33      = prod_abs[32:0];
    assign q0       = macc_reg[64:RECIP_SHIFT];
    assign rem      = {1'b0, x33} - pq_reg;
    assign q        = q0 + {19'd0, (rem >= {20'd0, DIV_BASE})};
    assign q_neg    = ~q + 20'd1;

    always_comb begin
        if (prod_sat) begin
            tgt_new = prod_reg[46] ? TGT_MIN : TGT_MAX;
        end else if (prod_reg[46]) begin
            tgt_new = $signed(q_neg);
        end else begin
            tgt_new = $signed(q);
        end
    end

    // pid operands of the wheel in work
    assign tgt_sel    = wheel_reg ? right_target_reg : left_target_reg;
    assign cur_sel    = wheel_reg ? $signed({cur_r_reg[15], cur_r_reg}) : cur_l_reg;
    assign last_sel   = wheel_reg ? right_err_last_reg : left_err_last_reg;
    assign older_sel  = wheel_reg ? right_err_older_reg : left_err_older_reg;
    assign acc_sel    = wheel_reg ? right_drive_acc_reg : left_drive_acc_reg;
    assign gain_p_sel = ramp_reg ? ramp_gain_p_reg : gain_p_reg;
    assign gain_i_sel = ramp_reg ? ramp_gain_i_reg : gain_i_reg;

    assign e1 = $signed({tgt_sel[19], tgt_sel}) - $signed({{4{cur_sel[16]}}, cur_sel});
    assign dp = $signed({e1[20], e1}) - $signed({last_sel[20], last_sel});
    assign dd = $signed({{2{e1[20]}}, e1}) - $signed({last_sel[20], last_sel, 1'b0})
              + $signed({{2{older_sel[20]}}, older_sel});

    // round half up then truncate toward zero, as one biased floor shift
    assign s_ext = {s_acc_reg[40], s_acc_reg};
    assign rnd   = s_ext + ((s_acc_reg < ROUND_EDGE) ? ROUND_NEG : ROUND_POS);

    assign acc_sum = $signed({{19{acc_sel[15]}}, acc_sel})
                   + $signed({delta_reg[33], delta_reg});

    always_comb begin
        if (acc_sum > $signed({{19{DRIVE_MAX[15]}}, DRIVE_MAX})) begin
            acc_new = DRIVE_MAX;
        end else if (acc_sum < $signed({{19{DRIVE_MIN[15]}}, DRIVE_MIN})) begin
            acc_new = DRIVE_MIN;
        end else begin
            acc_new = acc_sum[15:0];
        end
    end

    assign left_split  = split_drive(left_drive_acc_reg);
    assign right_split = split_drive(right_drive_acc_reg);
    assign count_sum   = $signed({cur_l_reg[16], cur_l_reg})
                       + $signed({{2{cur_r_reg[15]}}, cur_r_reg});

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MIX: begin
                mul_a = {err_s[16], err_s};
                mul_b = {19'd0, mix_sel};
            end
            ST_SCALE: begin
                mul_a = {3'd0, spd_reg};
                mul_b = {scale[31], scale};
            end
            ST_RECIP_HI: begin
                mul_a = {1'b0, x33[32:16]};
                mul_b = {1'b0, RECIP};
            end
            ST_RECIP_LO: begin
                mul_a = {2'd0, x33[15:0]};
                mul_b = {1'b0, RECIP};
            end
            ST_BACK: begin
                mul_a = {4'd0, DIV_BASE};
                mul_b = {13'd0, q0};
            end
            ST_PROP: begin
                mul_a = {2'd0, gain_p_sel};
                mul_b = {{11{dp[21]}}, dp};
            end
            ST_INTEG: begin
                mul_a = {2'd0, gain_i_sel};
                mul_b = {{12{e1[20]}}, e1};
            end
            ST_DERIV: begin
                mul_a = {2'd0, gain_d_reg};
                mul_b = {{10{dd[22]}}, dd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // register read
    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_P:         prdata = {16'd0, gain_p_reg};
            REG_GAIN_I:         prdata = {16'd0, gain_i_reg};
            REG_GAIN_D:         prdata = {16'd0, gain_d_reg};
            REG_RAMP_GAIN_P:    prdata = {16'd0, ramp_gain_p_reg};
            REG_RAMP_GAIN_I:    prdata = {16'd0, ramp_gain_i_reg};
            REG_STEER_MIX:      prdata = {18'd0, steer_mix_reg};
            REG_STOP_STEER_MIX: prdata = {18'd0, stop_steer_mix_reg};
            REG_STEER_CENTER:   prdata = {16'd0, steer_center_reg};
        endcase
    end

    // sequencer and next values
    always_comb begin
        state_next           = state_reg;
        wheel_next           = wheel_reg;
        m_valid_next         = m_valid_reg && !m_tready;
        gain_p_next          = gain_p_reg;
        gain_i_next          = gain_i_reg;
        gain_d_next          = gain_d_reg;
        ramp_gain_p_next     = ramp_gain_p_reg;
        ramp_gain_i_next     = ramp_gain_i_reg;
        steer_mix_next       = steer_mix_reg;
        stop_steer_mix_next  = stop_steer_mix_reg;
        steer_center_next    = steer_center_reg;
        left_target_next     = left_target_reg;
        right_target_next    = right_target_reg;
        left_err_last_next   = left_err_last_reg;
        left_err_older_next  = left_err_older_reg;
        right_err_last_next  = right_err_last_reg;
        right_err_older_next = right_err_older_reg;
        left_drive_acc_next  = left_drive_acc_reg;
        right_drive_acc_next = right_drive_acc_reg;
        cur_r_next           = cur_r_reg;
        cur_l_next           = cur_l_reg;
        steer_next           = steer_reg;
        spd_next             = spd_reg;
        stop_next            = stop_reg;
        ramp_next            = ramp_reg;
        me_next              = me_reg;
        prod_next            = prod_reg;
        macc_next            = macc_reg;
        pq_next              = pq_reg;
        s_acc_next           = s_acc_reg;
        delta_next           = delta_reg;
        m_data_next          = m_data_reg;

        if (cfg_we) begin
            unique case (cfg_idx)
                REG_GAIN_P:         gain_p_next         = pwdata[15:0];
                REG_GAIN_I:         gain_i_next         = pwdata[15:0];
                REG_GAIN_D:         gain_d_next         = pwdata[15:0];
                REG_RAMP_GAIN_P:    ramp_gain_p_next    = pwdata[15:0];
                REG_RAMP_GAIN_I:    ramp_gain_i_next    = pwdata[15:0];
                REG_STEER_MIX:      steer_mix_next      = pwdata[13:0];
                REG_STOP_STEER_MIX: stop_steer_mix_next = pwdata[13:0];
                REG_STEER_CENTER:   steer_center_next   = pwdata[15:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cur_r_next = $signed(s_tdata[15:0]);
                    cur_l_next = $signed(17'd0 - {s_tdata[31], s_tdata[31:16]});
                    steer_next = s_tdata[47:32];
                    spd_next   = s_tdata[62:48];
                    stop_next  = s_tuser[2];
                    ramp_next  = s_tuser[3];
                    wheel_next = 1'b0;
                    if (!s_tuser[0]) begin
                        left_drive_acc_next  = '0;
                        right_drive_acc_next = '0;
                        left_err_last_next   = '0;
                        left_err_older_next  = '0;
                        right_err_last_next  = '0;
                        right_err_older_next = '0;
                        state_next           = ST_WRITE;
                    end else if (s_tuser[2] || !s_tuser[1]) begin
                        state_next = ST_MIX;
                    end else begin
                        state_next = ST_PROP;
                    end
                end
            end
            ST_MIX: begin
                me_next    = mul_p[30:0];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                prod_next  = mul_p[46:0];
                state_next = ST_RECIP_HI;
            end
            ST_RECIP_HI: begin
                macc_next  = {16'd0, mul_p[48:0]};
                state_next = ST_RECIP_LO;
            end
            ST_RECIP_LO: begin
                macc_next  = {macc_reg[48:0], 16'd0} + {17'd0, mul_p[47:0]};
                state_next = ST_BACK;
            end
            ST_BACK: begin
                pq_next    = mul_p[33:0];
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (wheel_reg) begin
                    right_target_next = tgt_new;
                    wheel_next        = 1'b0;
                    state_next        = ST_PROP;
                end else begin
                    left_target_next = tgt_new;
                    wheel_next       = 1'b1;
                    state_next       = ST_SCALE;
                end
            end
            ST_PROP: begin
                s_acc_next = mul_p[40:0];
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                s_acc_next = s_acc_reg + mul_p[40:0];
                state_next = ST_DERIV;
            end
            ST_DERIV: begin
                s_acc_next = s_acc_reg + mul_p[40:0];
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                delta_next = rnd[41:8];
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (wheel_reg) begin
                    right_drive_acc_next = acc_new;
                    right_err_older_next = right_err_last_reg;
                    right_err_last_next  = e1;
                    wheel_next           = 1'b0;
                    state_next           = ST_WRITE;
                end else begin
                    left_drive_acc_next = acc_new;
                    left_err_older_next = left_err_last_reg;
                    left_err_last_next  = e1;
                    wheel_next          = 1'b1;
                    state_next          = ST_PROP;
                end
            end
            ST_WRITE: begin
                // disabled items reach here with zero accumulators
                if (out_free) begin
                    m_data_next  = {4'd0, count_sum[16:1],
                                    right_split[29:15], right_split[14:0],
                                    left_split[29:15], left_split[14:0],
                                    right_drive_acc_reg, left_drive_acc_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_r_reg  <= cur_r_next;
        cur_l_reg  <= cur_l_next;
        steer_reg  <= steer_next;
        spd_reg    <= spd_next;
        stop_reg   <= stop_next;
        ramp_reg   <= ramp_next;
        me_reg     <= me_next;
        prod_reg   <= prod_next;
        macc_reg   <= macc_next;
        pq_reg     <= pq_next;
        s_acc_reg  <= s_acc_next;
        delta_reg  <= delta_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            wheel_reg           <= 1'b0;
            m_valid_reg         <= 1'b0;
            gain_p_reg          <= '0;
            gain_i_reg          <= '0;
            gain_d_reg          <= '0;
            ramp_gain_p_reg     <= '0;
            ramp_gain_i_reg     <= '0;
            steer_mix_reg       <= '0;
            stop_steer_mix_reg  <= '0;
            steer_center_reg    <= '0;
            left_target_reg     <= '0;
            right_target_reg    <= '0;
            left_err_last_reg   <= '0;
            left_err_older_reg  <= '0;
            right_err_last_reg  <= '0;
            right_err_older_reg <= '0;
            left_drive_acc_reg  <= '0;
            right_drive_acc_reg <= '0;
        end else begin
            state_reg           <= state_next;
            wheel_reg           <= wheel_next;
            m_valid_reg         <= m_valid_next;
            gain_p_reg          <= gain_p_next;
            gain_i_reg          <= gain_i_next;
            gain_d_reg          <= gain_d_next;
            ramp_gain_p_reg     <= ramp_gain_p_next;
            ramp_gain_i_reg     <= ramp_gain_i_next;
            steer_mix_reg       <= steer_mix_next;
            stop_steer_mix_reg  <= stop_steer_mix_next;
            steer_center_reg    <= steer_center_next;
            left_target_reg     <= left_target_next;
            right_target_reg    <= right_target_next;
            left_err_last_reg   <= left_err_last_next;
            left_err_older_reg  <= left_err_older_next;
            right_err_last_reg  <= right_err_last_next;
            right_err_older_reg <= right_err_older_next;
            left_drive_acc_reg  <= left_drive_acc_next;
            right_drive_acc_reg <= right_drive_acc_next;
        end
    end

`ifndef NO_ASSERTIONS
    acc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_drive_acc_reg >= DRIVE_MIN && left_drive_acc_reg <= DRIVE_MAX &&
        right_drive_acc_reg >= DRIVE_MIN && right_drive_acc_reg <= DRIVE_MAX)
        else $error("drive accumulator out of range");

    disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=>
        left_drive_acc_reg == '0 && right_drive_acc_reg == '0 &&
        state_reg == ST_WRITE)
        else $error("disabled transfer did not clear the drives");

    one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[46:32] == '0 || m_tdata[61:47] == '0) &&
                     (m_tdata[76:62] == '0 || m_tdata[91:77] == '0))
        else $error("forward and reverse duty both active");
`endif

endmodule

`default_nettype wire
